/* rtl/core/mpbd_pkg.sv */
// ----------------------------------------------------------------------------
// mpbd_pkg
// Shared constants and types of the mip pyramid box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbd_pkg;

  // Level-0 map limits
  localparam int unsigned MAX_SIZE      = 1024;
  localparam int unsigned SIZE_LOG2_MAX = $clog2(MAX_SIZE);
  localparam int unsigned NUM_STAGES    = 10;
  localparam int unsigned ADDR_W        = $clog2(MAX_SIZE);
  localparam int unsigned POS_W         = 10;
  localparam int unsigned SUM_W         = 17;

  // Field widths
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned COORD_W  = 9;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned RES_W    = LEVEL_W + 2 * COORD_W + VALUE_W;
  localparam int unsigned TDATA_W  = ((RES_W + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_LOG2   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT = CFG_INDEX_W'(1);
  localparam logic [CFG_DATA_W-1:0]  SIZE_LOG2_RST   = CFG_DATA_W'(10);
  localparam logic [CFG_DATA_W-1:0]  LEVEL_COUNT_RST = CFG_DATA_W'(11);

  // One produced pixel; level sits in the lowest bits
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/mip_pyramid_box_downsampler.sv */
// ----------------------------------------------------------------------------
// mip_pyramid_box_downsampler
// Streaming 2x2 box-filter mip pyramid built with one shared level unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes level-0 heights in raster order, one request per pixel.
//   m_* returns every produced pixel of the coarser levels, finest level
//   first, tlast set on the final pixel caused by one input request.
//   cfg_* writes size_log2 (index 0) and level_count (index 1); any write
//   restarts the frame at pixel (0,0) of every level.
// Timing:
//   Level steps run one at a time in a single shared unit; the sequencer
//   walks the levels of one request and stalls while the hold register
//   waits on m_tready. A pixel-less request takes the accept and one step;
//   each produced pixel adds a step and a pair-sum read/average, plus a flush at level 10.
//   The pair-sum line is a 1024 x 17 memory with registered read.
// Reset:
//   Registers return to size_log2 = 10, level_count = 11 and all positions
//   to (0,0); the memory is not cleared (entries are written before read).
// Backpressure:
//   A single output register holds one pixel; the next pixel waits in a
//   hold register and the level walk stalls until m_tready frees a slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_pyramid_box_downsampler (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mpbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input pixels
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mpbd_pkg::HEIGHT_W-1:0]    s_tdata,  // [15:0] height
  // produced pixels
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [mpbd_pkg::TDATA_W-1:0]          m_tdata,  // level, col, row, value, zero pad
  output logic                                  m_tlast   // last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STEP  = 2'd1;
  localparam logic [1:0] ST_AVG   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam int unsigned LW  = mpbd_pkg::LEVEL_W;
  localparam int unsigned PW  = mpbd_pkg::POS_W;
  localparam int unsigned SW  = mpbd_pkg::SUM_W;
  localparam int unsigned AW  = mpbd_pkg::ADDR_W;
  localparam int unsigned HW  = mpbd_pkg::HEIGHT_W;
  localparam int unsigned CW  = mpbd_pkg::COORD_W;
  localparam int unsigned NS  = mpbd_pkg::NUM_STAGES;
  localparam int unsigned SZW = mpbd_pkg::SIZE_LOG2_MAX + 1;

  logic [1:0]    state;
  logic [mpbd_pkg::CFG_DATA_W-1:0] size_log2;
  logic [mpbd_pkg::CFG_DATA_W-1:0] level_count;

  logic [PW-1:0] stage_col [NS];
  logic [PW-1:0] stage_row [NS];
  logic [HW-1:0] left_pixel [NS];
  logic [SW-1:0] pair_sum_lines [mpbd_pkg::MAX_SIZE];

  logic [LW-1:0] lvl;
  logic [HW-1:0] pix;
  logic [SW-1:0] pair_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] row_r;
  logic [SW-1:0] rd_data;

  mpbd_pkg::result_t hold;
  logic              hold_valid;
  mpbd_pkg::result_t out_res;
  logic              out_valid;
  logic              out_last;

  // effective configuration
  logic [LW-1:0]  s_eff;
  logic [LW-1:0]  levels_eff;
  logic [LW-1:0]  wlog;
  logic [SZW-1:0] size_w;
  logic [SZW-1:0] w;
  logic [PW-1:0]  wm1;
  logic [PW-1:0]  x_raw, y_raw, xe, ye;
  logic           col_end, row_end;
  logic [LW:0]    lvl_p1;
  logic           brk, produce;
  logic [SW-1:0]  pair;
  logic [SZW-1:0] idx_full;
  logic [AW-1:0]  idx;
  logic           out_free, step_go, push, cfg_we, accept;
  logic [SW+1:0]  avg_sum;

  always_comb begin
    if (size_log2 == '0) begin
      s_eff = LW'(1);
    end else if (size_log2 > LW'(mpbd_pkg::SIZE_LOG2_MAX)) begin
      s_eff = LW'(mpbd_pkg::SIZE_LOG2_MAX);
    end else begin
      s_eff = size_log2;
    end
    levels_eff = (level_count > s_eff + LW'(1)) ? s_eff + LW'(1) : level_count;
  end

  // shared level unit: position, pairing and memory address of level lvl
  always_comb begin
    wlog     = s_eff - lvl;
    size_w   = SZW'(1) << s_eff;
    w        = SZW'(1) << wlog;
    wm1      = PW'(w - SZW'(1));
    x_raw    = stage_col[lvl];
    y_raw    = stage_row[lvl];
    if (x_raw > wm1 || y_raw > wm1) begin
      xe = '0;
      ye = '0;
    end else begin
      xe = x_raw;
      ye = y_raw;
    end
    col_end  = (xe == wm1);
    row_end  = (ye == wm1);
    lvl_p1   = {1'b0, lvl} + (LW+1)'(1);
    brk      = (levels_eff < LW'(2)) || (lvl_p1 >= {1'b0, levels_eff});
    produce  = !brk && xe[0] && ye[0];
    pair     = SW'(left_pixel[lvl]) + SW'(pix);
    idx_full = size_w - w + SZW'(xe >> 1);
    idx      = idx_full[AW-1:0];
    avg_sum  = (SW+2)'(rd_data) + (SW+2)'(pair_r) + (SW+2)'(2);
  end

  assign out_free  = !out_valid || m_tready;
  assign step_go   = !hold_valid || out_free;
  assign push      = (state == ST_STEP && step_go && hold_valid) ||
                     (state == ST_FLUSH && out_free);
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (step_go) begin
            hold_valid <= 1'b0;
            state      <= produce ? ST_AVG : ST_IDLE;
          end
        end
        ST_AVG: begin
          hold_valid <= 1'b1;
          state      <= (lvl_p1 == (LW+1)'(NS)) ? ST_FLUSH : ST_STEP;
        end
        ST_FLUSH: begin
          if (out_free) begin
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // configuration and level positions
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2   <= mpbd_pkg::SIZE_LOG2_RST;
      level_count <= mpbd_pkg::LEVEL_COUNT_RST;
      for (int i = 0; i < NS; i++) begin
        stage_col[i] <= '0;
        stage_row[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == mpbd_pkg::REG_SIZE_LOG2) begin
        size_log2 <= cfg_data;
      end else if (cfg_index == mpbd_pkg::REG_LEVEL_COUNT) begin
        level_count <= cfg_data;
      end
      for (int i = 0; i < NS; i++) begin
        stage_col[i] <= '0;
        stage_row[i] <= '0;
      end
    end else if (state == ST_STEP && step_go) begin
      if (col_end) begin
        stage_col[lvl] <= '0;
        stage_row[lvl] <= row_end ? '0 : ye + PW'(1);
      end else begin
        stage_col[lvl] <= xe + PW'(1);
        stage_row[lvl] <= ye;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pix <= s_tdata;
      lvl <= '0;
    end
    if (state == ST_STEP && step_go) begin
      if (!brk && !xe[0]) begin
        left_pixel[lvl] <= pix;
      end
      pair_r <= pair;
      col_r  <= CW'(xe >> 1);
      row_r  <= CW'(ye >> 1);
    end
    if (state == ST_AVG) begin
      hold.level <= lvl_p1[LW-1:0];
      hold.col   <= col_r;
      hold.row   <= row_r;
      hold.value <= avg_sum[SW:2];
      pix        <= avg_sum[SW:2];
      lvl        <= lvl_p1[LW-1:0];
    end
  end

  // pair-sum line memory
  always_ff @(posedge clk) begin
    if (state == ST_STEP && step_go && !brk && xe[0]) begin
      if (!ye[0]) begin
        pair_sum_lines[idx] <= pair;
      end else begin
        rd_data <= pair_sum_lines[idx];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res  <= hold;
      out_last <= (state == ST_FLUSH) || !produce;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = mpbd_pkg::TDATA_W'(out_res);
  assign m_tlast  = out_last;

  // the hold slot is drained before a new request is taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !hold_valid)
    else $error("hold register still full while idle");

  // averaging starts only after the previous pixel left the hold slot
  a_avg_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_AVG |-> !hold_valid)
    else $error("hold register overwritten");

  // an accepted request starts the level walk at level 0
  a_accept_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_STEP && lvl == '0)
    else $error("level walk did not start");

  // produced pixels never come from level 0 nor beyond the deepest stage
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.level >= LW'(1) && out_res.level <= LW'(NS))
    else $error("produced level out of range");

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mip pyramid box downsampler. A queue-fed driver
// streams level-0 heights into the block and an in-bench pyramid predictor
// computes the pixels of every coarser level. A monitor compares each
// returned pixel, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mpbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned                 CYCLE_LIMIT = 200000;
  localparam int unsigned                 DRAIN       = 40;
  localparam int unsigned                 LONG_HOLD   = 300;
  localparam int unsigned                 NUM_ITEMS   = 220;
  localparam logic [CFG_INDEX_W-1:0]      REG_UNUSED  = CFG_INDEX_W'(255);

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [VALUE_W-1:0] value;
    logic               last;
  } pixel_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [HEIGHT_W-1:0]    s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [TDATA_W-1:0]     m_tdata;
  logic                   m_tlast;

  mip_pyramid_box_downsampler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state: configuration, pair-sum lines, left pixels, positions
  logic [CFG_DATA_W-1:0] cur_size_log2   = SIZE_LOG2_RST;
  logic [CFG_DATA_W-1:0] cur_level_count = LEVEL_COUNT_RST;
  logic [SUM_W-1:0]      line_sum [MAX_SIZE];
  logic [VALUE_W-1:0]    left_px  [NUM_STAGES];
  int unsigned           pos_col  [NUM_STAGES];
  int unsigned           pos_row  [NUM_STAGES];

  logic [HEIGHT_W-1:0] height_queue [$];
  pixel_t              expected_pixels [$];

  int unsigned heights_queued = 0;
  int unsigned heights_taken  = 0;
  int unsigned pixels_seen    = 0;
  int unsigned reg_writes     = 0;
  int unsigned deepest_level  = 0;
  int unsigned fails          = 0;
  int unsigned cycles         = 0;

  logic        s_fired       = 1'b0;
  logic        cfg_fired     = 1'b0;
  int unsigned idle_odds     = 0;
  int unsigned send_gap      = 0;
  int unsigned ready_gap     = 0;
  logic        hold_request  = 1'b0;
  logic        hold_done     = 1'b0;
  int unsigned hold_left     = 0;

  initial begin
    for (int i = 0; i < MAX_SIZE; i++) line_sum[i] = '0;
    for (int i = 0; i < NUM_STAGES; i++) begin
      left_px[i] = '0;
      pos_col[i] = 0;
      pos_row[i] = 0;
    end
  end

  function automatic int unsigned eff_size_log2(input logic [CFG_DATA_W-1:0] raw);
    int unsigned s;
    s = raw;
    if (s < 1) s = 1;
    while (s > 1 && (1 << s) > MAX_SIZE) s--;
    return s;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_SIZE_LOG2) cur_size_log2 = val;
    else if (idx == REG_LEVEL_COUNT) cur_level_count = val;
    // any write restarts the frame
    for (int i = 0; i < NUM_STAGES; i++) begin
      pos_col[i] = 0;
      pos_row[i] = 0;
    end
  endfunction

  // Walk one height down the level cascade and queue the pixels it produces
  function automatic void cascade_levels(input logic [HEIGHT_W-1:0] h);
    int unsigned s, map_w, levels, lv, w, x, y, idx, total;
    logic [SUM_W-1:0]   pair;
    logic [VALUE_W-1:0] pix;
    pixel_t             px;
    int unsigned        first;
    s      = eff_size_log2(cur_size_log2);
    map_w  = 1 << s;
    levels = cur_level_count;
    if (levels > s + 1) levels = s + 1;
    if (levels > NUM_STAGES + 1) levels = NUM_STAGES + 1;
    pix   = h;
    first = expected_pixels.size();
    for (lv = 0; lv < NUM_STAGES; lv++) begin
      w = map_w >> lv;
      x = pos_col[lv];
      y = pos_row[lv];
      if (x >= w || y >= w) begin
        x = 0;
        y = 0;
      end
      if (x + 1 >= w) begin
        pos_col[lv] = 0;
        pos_row[lv] = (y + 1 >= w) ? 0 : y + 1;
      end else begin
        pos_col[lv] = x + 1;
        pos_row[lv] = y;
      end
      if (levels < 2 || lv + 1 >= levels) break;
      if (x[0] == 1'b0) begin
        left_px[lv] = pix;
        break;
      end
      pair = SUM_W'(left_px[lv]) + SUM_W'(pix);
      idx  = (map_w - w + (x >> 1)) & (MAX_SIZE - 1);
      if (y[0] == 1'b0) begin
        line_sum[idx] = pair;
        break;
      end
      total    = int'(line_sum[idx]) + int'(pair) + 2;
      px.level = LEVEL_W'(lv + 1);
      px.col   = COORD_W'(x >> 1);
      px.row   = COORD_W'(y >> 1);
      px.value = VALUE_W'(total >> 2);
      px.last  = 1'b0;
      expected_pixels.insert(expected_pixels.size(), px);
      pix = px.value;
    end
    if (expected_pixels.size() > first)
      expected_pixels[expected_pixels.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_pixel();
    result_t got;
    pixel_t  want;
    got = result_t'(m_tdata[RES_W-1:0]);
    pixels_seen++;
    if (int'(got.level) > deepest_level) deepest_level = got.level;
    if (m_tdata[TDATA_W-1:RES_W] != '0) begin
      $error("pad: expected 0 actual %0h", m_tdata[TDATA_W-1:RES_W]);
      fails++;
    end
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel: level %0d col %0d row %0d value %0d",
             got.level, got.col, got.row, got.value);
      fails++;
      return;
    end
    want = expected_pixels.pop_front();
    if (got.level !== want.level) begin
      $error("level: expected %0d actual %0d", want.level, got.level);
      fails++;
    end
    if (got.col !== want.col) begin
      $error("col: expected %0d actual %0d", want.col, got.col);
      fails++;
    end
    if (got.row !== want.row) begin
      $error("row: expected %0d actual %0d", want.row, got.row);
      fails++;
    end
    if (got.value !== want.value) begin
      $error("value: expected %0d actual %0d", want.value, got.value);
      fails++;
    end
    if (m_tlast !== want.last) begin
      $error("last: expected %0d actual %0d", want.last, m_tlast);
      fails++;
    end
  endfunction

  // Monitor: sample every handshake at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      s_fired   <= 1'b0;
      cfg_fired <= 1'b0;
    end else begin
      s_fired   <= s_tvalid && s_tready;
      cfg_fired <= cfg_valid && cfg_ready;
      if (m_tvalid && m_tready) check_pixel();
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (s_tvalid && s_tready) begin
        cascade_levels(s_tdata);
        heights_taken++;
      end
    end
  end

  // Driver: offer queued heights, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_fired) begin
      // hold the pending request
    end else if (send_gap > 0) begin
      s_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (height_queue.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      s_tvalid <= 1'b0;
      send_gap <= $urandom_range(0, 2);
    end else begin
      s_tvalid <= 1'b1;
      s_tdata  <= height_queue.pop_front();
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  // Receiver: random short stalls plus the long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      m_tready  <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      m_tready  <= 1'b0;
      ready_gap <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_height(input logic [HEIGHT_W-1:0] h);
    height_queue.insert(height_queue.size(), h);
    heights_queued++;
  endtask

  // Wait until all heights are in and all pixels are out, then let the
  // level walk of a pixel-less request finish
  task automatic settle();
    while (heights_taken != heights_queued || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_fired) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned           sent, count, frame, sz_eff, pick;
    logic [CFG_DATA_W-1:0] sz, lc;
    sent = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: full-scale extremes, rounding, restart, single level
    idle_odds = 4;
    write_reg(REG_SIZE_LOG2, CFG_DATA_W'(1));
    write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(2));
    repeat (4) queue_height('1);
    queue_height(16'd0); queue_height(16'd1); queue_height(16'd1); queue_height(16'd0);
    queue_height(HEIGHT_W'($urandom));
    queue_height(HEIGHT_W'($urandom));
    // restart mid-frame through an index beyond the register list
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    repeat (4) queue_height(HEIGHT_W'($urandom));
    write_reg(REG_SIZE_LOG2, CFG_DATA_W'(15));
    repeat (2) queue_height(HEIGHT_W'($urandom));
    write_reg(REG_SIZE_LOG2, CFG_DATA_W'(1));
    write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(0));
    repeat (4) queue_height(HEIGHT_W'($urandom));
    write_reg(REG_SIZE_LOG2, CFG_DATA_W'(0));
    write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(15));
    repeat (4) queue_height(HEIGHT_W'($urandom));

    // Random: mostly whole frames at small sizes, some cut-off frames
    sent   = heights_queued;
    sz_eff = 1;
    while (sent < NUM_ITEMS) begin
      if (sent >= 170) idle_odds = 0;
      else begin
        pick = $urandom_range(0, 2);
        idle_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 6;
      end
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        sz = (pick == 0) ? 4'd0 : (pick <= 3) ? 4'd1 : (pick <= 6) ? 4'd2 :
             (pick <= 8) ? 4'd3 : 4'd4;
        lc = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 15)) :
                                            CFG_DATA_W'($urandom_range(2, 11));
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_SIZE_LOG2, sz);
          write_reg(REG_LEVEL_COUNT, lc);
        end else begin
          write_reg(REG_LEVEL_COUNT, lc);
          write_reg(REG_SIZE_LOG2, sz);
        end
        if ($urandom_range(0, 5) == 0)
          write_reg(CFG_INDEX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
        sz_eff = eff_size_log2(sz);
      end
      frame = 1 << (2 * sz_eff);
      if (sz_eff >= 4)
        count = $urandom_range(20, 48);
      else if ($urandom_range(0, 4) == 0)
        count = $urandom_range(1, frame);
      else
        count = frame * $urandom_range(1, 2);
      // once, starve the output long enough to back up the input
      if (!hold_request && sent >= 60) begin
        write_reg(REG_SIZE_LOG2, CFG_DATA_W'(2));
        write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(11));
        sz_eff       = 2;
        count        = 2 * (1 << (2 * sz_eff));
        hold_request = 1'b1;
      end
      if (count > NUM_ITEMS - sent) count = NUM_ITEMS - sent;
      repeat (count) queue_height(pick_height());
      sent += count;
    end

    settle();
    $display("Sent %0d heights across %0d register writes, maps of 2 to 16 pixels",
             heights_queued, reg_writes);
    $display("and one clamped oversize map; %0d pixels checked, deepest level %0d.",
             pixels_seen, deepest_level);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/mpbd_pkg.sv
rtl/core/mip_pyramid_box_downsampler.sv
dv/tb.sv
